>>> sv/kdle_pkg.sv
// Shared constants, types and helpers for the key debounce and event queue block.
`timescale 1ns / 1ps

package kdle_pkg;

    // Sizing
    localparam int NUM_KEYS    = 5;
    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_AW      = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 5;
    localparam int CFG_W    = 16;
    localparam int EV_KEY_W = 3;
    localparam int EV_KND_W = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;

    // Register indexes
    typedef enum logic [0:0] {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } reg_idx_t;

    // Command codes
    typedef enum logic [0:0] {
        OP_SCAN = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Event kinds
    typedef enum logic [EV_KND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_LONG    = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    // Per-key phase; code 3 is never written
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2
    } phase_t;

    // One key state entry (all zero is the reset value)
    typedef struct packed {
        phase_t              phase;
        logic [TIME_W-1:0]   start;
        logic                long_done;
    } key_entry_t;

    // One queued event
    typedef struct packed {
        logic [EV_KEY_W-1:0] key;
        kind_t               kind;
    } event_rec_t;

    // Advance a ring pointer modulo the queue depth
    function automatic logic [QAW-1:0] qptr_inc(input logic [QAW-1:0] ptr);
        logic [QAW-1:0] res;
        if (ptr == QAW'(QUEUE_DEPTH - 1))
            res = '0;
        else
            res = QAW'(ptr + 1'b1);
        return res;
    endfunction

endpackage

>>> sv/kdle_if.sv
// Valid/ready channel interfaces for commands, events and register writes.
`timescale 1ns / 1ps

interface kdle_cmd_if
    import kdle_pkg::*;
();
    logic               valid;
    logic               ready;
    op_t                op;
    logic [TIME_W-1:0]  time_ms;
    logic [LEVEL_W-1:0] key_levels;

    modport source (output valid, op, time_ms, key_levels, input ready);
    modport sink   (input valid, op, time_ms, key_levels, output ready);
endinterface

interface kdle_evt_if
    import kdle_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                event_valid;
    logic [EV_KEY_W-1:0] event_key;
    logic [EV_KND_W-1:0] event_kind;

    modport source (output valid, event_valid, event_key, event_kind, input ready);
    modport sink   (input valid, event_valid, event_key, event_kind, output ready);
endinterface

interface kdle_cfg_if
    import kdle_pkg::*;
();
    logic             valid;
    logic             ready;
    reg_idx_t         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/kdle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module kdle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/key_debounce_longpress_events.sv
// Top level: per-key debounce and long-press machines feeding an event ring.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------
//  cmd     | in  | valid/ready | op, time_ms, key_levels
//  evt     | out | valid/ready | event_valid, event_key, event_kind
//  cfg     | in  | valid/ready | index (0 debounce, 1 long press), data
//
//  A scan does one key state RAM read/modify/write per cycle, the first read
//  issued in the accept cycle.
//  A pop does one event RAM read, then the output register load.
//  Reset clears key states through per-key valid flops; no clearing pass.
//  cmd is refused while a command is in flight; a pop waits while a previous
//  event still sits unclaimed in the output register. cfg is always ready.
`timescale 1ns / 1ps

module key_debounce_longpress_events
    import kdle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kdle_cmd_if.sink    cmd,
    kdle_evt_if.source  evt,
    kdle_cfg_if.sink    cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP
    } state_t;

    localparam int KS_W = $bits(key_entry_t);
    localparam int EV_W = $bits(event_rec_t);

    state_t              state_reg;
    logic [KEY_AW-1:0]   key_idx_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [LEVEL_W-1:0]  levels_reg;
    logic [NUM_KEYS-1:0] kvalid_reg;
    logic [QAW-1:0]      rp_reg;
    logic [QAW-1:0]      wp_reg;
    logic                pop_empty_reg;
    logic [CFG_W-1:0]    dbnc_reg;
    logic [CFG_W-1:0]    lp_reg;
    logic                fwd_hit_reg;
    key_entry_t          fwd_data_reg;
    logic                out_valid_reg;
    logic                out_ev_reg;
    logic [EV_KEY_W-1:0] out_key_reg;
    logic [EV_KND_W-1:0] out_kind_reg;

    logic                cmd_fire;
    logic                last_key;
    logic [KEY_AW-1:0]   key_raddr;
    logic [KS_W-1:0]     key_rdata;
    key_entry_t          cur;
    key_entry_t          nxt;
    logic                key_we;
    logic [LEVEL_W-1:0]  lv_shift;
    logic                pressed;
    logic [TIME_W-1:0]   elapsed;
    logic                deb_ok;
    logic                long_ok;
    logic                ev_push;
    kind_t               ev_kind;
    logic [QAW-1:0]      wp_next;
    logic                q_full;
    logic                ev_we;
    event_rec_t          ev_wdata;
    logic [EV_W-1:0]     ev_rdata;
    event_rec_t          ev_rec;
    logic                out_free;

    // Handshakes
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || evt.ready;

    assign evt.valid       = out_valid_reg;
    assign evt.event_valid = out_ev_reg;
    assign evt.event_key   = out_key_reg;
    assign evt.event_kind  = out_kind_reg;

    // Key state RAM: read next key while the current one is written back
    assign last_key  = (key_idx_reg == KEY_AW'(NUM_KEYS - 1));
    assign key_raddr = (state_reg == S_SCAN && !last_key) ? KEY_AW'(key_idx_reg + 1'b1)
                                                           : '0;
    assign key_we    = (state_reg == S_SCAN);

    kdle_ram #(
        .WIDTH (KS_W),
        .DEPTH (NUM_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_idx_reg),
        .wdata (nxt),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    // Pick the current key state: reset value, forwarded write, or RAM data
    always_comb
    begin
        if (!kvalid_reg[key_idx_reg])
            cur = '0;
        else if (fwd_hit_reg)
            cur = fwd_data_reg;
        else
            cur = key_entry_t'(key_rdata);
    end

    // Level of the current key; keys past the level bits read as pressed
    assign lv_shift = LEVEL_W'(levels_reg >> key_idx_reg);
    assign pressed  = ~lv_shift[0];
    assign elapsed  = time_reg - cur.start;
    assign deb_ok   = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, dbnc_reg});
    assign long_ok  = (elapsed >= {{(TIME_W-CFG_W){1'b0}}, lp_reg});

    // Advance the key machine
    always_comb
    begin
        nxt     = cur;
        ev_push = 1'b0;
        ev_kind = KIND_PRESS;
        case (cur.phase)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    nxt.phase = PH_DEBOUNCE;
                    nxt.start = time_reg;
                end
            end
            PH_DEBOUNCE:
            begin
                if (!pressed)
                begin
                    nxt.phase = PH_IDLE;
                end
                else if (deb_ok)
                begin
                    nxt.phase     = PH_PRESSED;
                    nxt.start     = time_reg;
                    nxt.long_done = 1'b0;
                    ev_push       = 1'b1;
                    ev_kind       = KIND_PRESS;
                end
            end
            PH_PRESSED:
            begin
                if (!pressed)
                begin
                    nxt.phase = PH_IDLE;
                    ev_push   = 1'b1;
                    ev_kind   = KIND_RELEASE;
                end
                else if (!cur.long_done && long_ok)
                begin
                    nxt.long_done = 1'b1;
                    ev_push       = 1'b1;
                    ev_kind       = KIND_LONG;
                end
            end
            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase
    end

    // Event ring: drop when full
    assign wp_next       = qptr_inc(wp_reg);
    assign q_full        = (wp_next == rp_reg);
    assign ev_we         = key_we && ev_push && !q_full;
    assign ev_wdata.key  = EV_KEY_W'(key_idx_reg);
    assign ev_wdata.kind = ev_kind;

    kdle_ram #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_evt_ram (
        .clk   (clk),
        .we    (ev_we),
        .waddr (wp_reg),
        .wdata (ev_wdata),
        .raddr (rp_reg),
        .rdata (ev_rdata)
    );

    assign ev_rec = event_rec_t'(ev_rdata);

    // Hold scan operands and the forwarding copy of the last write
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            time_reg   <= cmd.time_ms;
            levels_reg <= cmd.key_levels;
        end
        fwd_data_reg <= nxt;
    end

    // Control state, registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_idx_reg   <= '0;
            kvalid_reg    <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            pop_empty_reg <= 1'b0;
            dbnc_reg      <= DEBOUNCE_RST;
            lp_reg        <= LONG_PRESS_RST;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= 1'b0;
            out_key_reg   <= '0;
            out_kind_reg  <= '0;
        end
        else
        begin
            fwd_hit_reg <= key_we && (key_idx_reg == key_raddr);

            // Register writes; unknown indexes never occur with a one-bit index
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_DEBOUNCE:   dbnc_reg <= cfg.data;
                    REG_LONG_PRESS: lp_reg   <= cfg.data;
                    default:        dbnc_reg <= dbnc_reg;
                endcase
            end

            // Drop a taken event unless a pop reloads the output register
            if (out_valid_reg && evt.ready && state_reg != S_POP)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        key_idx_reg   <= '0;
                        pop_empty_reg <= (rp_reg == wp_reg);
                        if (cmd.op == OP_POP)
                            state_reg <= S_POP;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    kvalid_reg[key_idx_reg] <= 1'b1;
                    if (ev_we)
                        wp_reg <= wp_next;
                    if (last_key)
                        state_reg <= S_IDLE;
                    else
                        key_idx_reg <= KEY_AW'(key_idx_reg + 1'b1);
                end
                S_POP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (pop_empty_reg)
                        begin
                            out_ev_reg   <= 1'b0;
                            out_key_reg  <= '0;
                            out_kind_reg <= '0;
                        end
                        else
                        begin
                            out_ev_reg   <= 1'b1;
                            out_key_reg  <= ev_rec.key;
                            out_kind_reg <= ev_rec.kind;
                            rp_reg       <= qptr_inc(rp_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (out_valid_reg && evt.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/kdle_checker.sv
// Port-level checker for the key debounce block, bound to the top level.
`timescale 1ns / 1ps

module kdle_checker
    import kdle_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                cmd_op,
    input logic                evt_valid,
    input logic                evt_ready,
    input logic                evt_event_valid,
    input logic [EV_KEY_W-1:0] evt_event_key,
    input logic [EV_KND_W-1:0] evt_event_kind
);

    // An empty pop reports all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_event_valid |-> evt_event_key == '0 && evt_event_kind == '0)
        else $error("empty pop carries nonzero fields");

    // A real event names an existing key and a defined kind
    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_event_valid |->
            evt_event_key < EV_KEY_W'(NUM_KEYS) && evt_event_kind <= KIND_RELEASE)
        else $error("event key or kind out of range");

    // A scan transaction keeps the command channel busy on the next cycle
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_op == OP_SCAN |=> !cmd_ready)
        else $error("command accepted during a scan");

    // A stalled event holds its payload
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_valid) &&
            $stable(evt_event_key) && $stable(evt_event_kind))
        else $error("stalled event changed");

endmodule

bind key_debounce_longpress_events kdle_checker u_kdle_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_op          (cmd.op),
    .evt_valid       (evt.valid),
    .evt_ready       (evt.ready),
    .evt_event_valid (evt.event_valid),
    .evt_event_key   (evt.event_key),
    .evt_event_kind  (evt.event_kind)
);
